>>> hw/rtl/addressed_command_frame_parser_assert.svh
// Assertion macros shared by the frame parser modules.
`ifndef ADDRESSED_COMMAND_FRAME_PARSER_ASSERT_SVH
`define ADDRESSED_COMMAND_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ACFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ACFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/acfp_pkg.sv
// Types, constants and codes of the addressed command frame parser.
package acfp_pkg;

  localparam int ACFP_BUF_DEPTH = 32;
  localparam int FRAME_LEN      = 18;

  localparam int ADC_W     = 10;
  localparam int ADC_SCALE = 500;
  localparam int ADC_FULL  = 1023;
  localparam int PROD_W    = 19;
  localparam int VAL_W     = 9;

  localparam logic [7:0] CHAR_E      = 8'h65;
  localparam logic [7:0] CHAR_C      = 8'h43;
  localparam logic [7:0] CHAR_R      = 8'h52;
  localparam logic [7:0] CHAR_P      = 8'h50;
  localparam logic [7:0] CHAR_A      = 8'h41;
  localparam logic [7:0] CHAR_O      = 8'h4F;
  localparam logic [7:0] CHAR_LBRACK = 8'h5B;
  localparam logic [7:0] CHAR_RBRACK = 8'h5D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_TWO    = 8'h32;
  localparam logic [7:0] CHAR_FOUR   = 8'h34;

  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_DATA = 2'd1;
  localparam logic [1:0] KIND_REF  = 2'd2;

  typedef enum logic [2:0] {
    SEL_ECHO,
    SEL_REF,
    SEL_HUND,
    SEL_TENS,
    SEL_ONES,
    SEL_LETTER
  } out_sel_t;

  typedef enum logic [1:0] {
    REPLY_NONE,
    REPLY_REF,
    REPLY_CO
  } reply_t;

  typedef struct packed {
    logic     capture;
    logic     decode;
    logic     load;
    out_sel_t sel;
    logic     last;
  } acfp_cmd_t;

  typedef struct packed {
    reply_t reply;
    logic   out_free;
  } acfp_stat_t;

endpackage

>>> hw/rtl/acfp_if.sv
// Channel interfaces of the frame parser: input, result and configuration.
interface acfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic [9:0] adc_value;
  modport source (output valid, output rx_byte, output adc_value, input ready);
  modport sink (input valid, input rx_byte, input adc_value, output ready);
endinterface

interface acfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] ref_number;
  logic [2:0] mode;
  logic       last;
  modport source (output valid, output kind, output out_byte, output ref_number,
                  output mode, output last, input ready);
  modport sink (input valid, input kind, input out_byte, input ref_number,
                input mode, input last, output ready);
endinterface

interface acfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] device_address;
  modport source (output valid, output device_address, input ready);
  modport sink (input valid, input device_address, output ready);
endinterface

>>> hw/rtl/acfp_dpath.sv
// Datapath: receive and frame buffers, command decode, scaling, output register.
module acfp_dpath #(
  parameter int BUF_DEPTH = acfp_pkg::ACFP_BUF_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            rx_byte,
  input  logic [9:0]            adc_value,
  input  acfp_pkg::acfp_cmd_t   cmd,
  output acfp_pkg::acfp_stat_t  stat,
  acfp_cfg_if.sink              cfg_ch,
  acfp_out_if.source            out_ch
);
  import acfp_pkg::*;
`include "addressed_command_frame_parser_assert.svh"

  localparam int FILL_W = $clog2(BUF_DEPTH);

  logic [7:0]        rx_r [FRAME_LEN];
  logic [7:0]        frame_r [FRAME_LEN];
  logic [FILL_W-1:0] fill_r;
  logic [4:0]        addr_r;
  logic [2:0]        mode_r;
  logic [7:0]        byte_r;
  reply_t            reply_r;
  logic [1:0]        ref_r;

  logic [PROD_W-1:0] prod_r;
  logic [VAL_W-1:0]  val_r;
  logic [2:0]        hund_r;
  logic [6:0]        rem_r;
  logic [3:0]        tens_r;
  logic [3:0]        ones_r;

  logic              out_valid_r;
  logic [1:0]        kind_r;
  logic [7:0]        obyte_r;
  logic [1:0]        oref_r;
  logic [2:0]        omode_r;
  logic              olast_r;

  logic              addr_ok;
  logic              cr_frame;
  logic              pa_frame;
  logic              co_frame;
  logic              is_end;
  reply_t            reply_nxt;
  logic [1:0]        ref_nxt;
  logic              mode_set;
  logic [VAL_W-1:0]  quot;
  logic [10:0]       part_sum;
  logic [VAL_W-1:0]  val_nxt;
  logic [2:0]        hund_nxt;
  logic [6:0]        rem_nxt;
  logic [3:0]        tens_nxt;
  logic [3:0]        ones_nxt;
  logic [1:0]        kind_nxt;
  logic [7:0]        obyte_nxt;
  logic [1:0]        oref_nxt;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else if (cfg_ch.valid) begin
      addr_r <= cfg_ch.device_address;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        if (fill_r == FILL_W'(i)) begin
          rx_r[i] <= rx_byte;
        end
      end
      byte_r <= rx_byte;
      prod_r <= PROD_W'(adc_value) * PROD_W'(ADC_SCALE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int i = 0; i < FRAME_LEN; i++) begin
        frame_r[i] <= '0;
      end
    end else if (cmd.capture) begin
      if (rx_byte == CHAR_E) begin
        for (int i = 0; i < FRAME_LEN; i++) begin
          if (fill_r > FILL_W'(i)) begin
            frame_r[i] <= rx_r[i];
          end
        end
        fill_r <= '0;
      end else if (fill_r < FILL_W'(BUF_DEPTH - 1)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  always_comb begin
    addr_ok = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (frame_r[6 + k] != {CHAR_ZERO[7:1], addr_r[k]}) begin
        addr_ok = 1'b0;
      end
    end
    is_end   = (byte_r == CHAR_E);
    cr_frame = frame_r[0] == CHAR_LBRACK && frame_r[1] == CHAR_C && frame_r[2] == CHAR_R &&
               frame_r[3] == CHAR_COMMA && frame_r[5] == CHAR_COMMA &&
               frame_r[11] == CHAR_RBRACK;
    pa_frame = frame_r[0] == CHAR_LBRACK && frame_r[1] == CHAR_P && frame_r[2] == CHAR_A &&
               frame_r[3] == CHAR_COMMA && frame_r[5] == CHAR_COMMA &&
               frame_r[11] == CHAR_COMMA && frame_r[14] == CHAR_COMMA &&
               frame_r[17] == CHAR_RBRACK;
    co_frame = frame_r[0] == CHAR_LBRACK && frame_r[1] == CHAR_C && frame_r[2] == CHAR_O &&
               frame_r[3] == CHAR_COMMA && frame_r[5] == CHAR_COMMA &&
               frame_r[11] == CHAR_COMMA && frame_r[14] == CHAR_COMMA &&
               frame_r[17] == CHAR_RBRACK;
    reply_nxt = REPLY_NONE;
    ref_nxt   = 2'd0;
    mode_set  = 1'b0;
    if (is_end && addr_ok) begin
      priority if (cr_frame) begin
        if (frame_r[4] == CHAR_ONE) begin
          reply_nxt = REPLY_REF;
          ref_nxt   = 2'd1;
        end else if (frame_r[4] == CHAR_TWO) begin
          reply_nxt = REPLY_REF;
          ref_nxt   = 2'd2;
        end
      end else if (pa_frame) begin
        mode_set = (frame_r[4] >= CHAR_ONE) && (frame_r[4] <= CHAR_FOUR);
      end else if (co_frame) begin
        if (frame_r[4] == CHAR_ONE) begin
          reply_nxt = REPLY_CO;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= '0;
      reply_r <= REPLY_NONE;
      ref_r   <= '0;
    end else if (cmd.decode) begin
      reply_r <= reply_nxt;
      ref_r   <= ref_nxt;
      if (mode_set) begin
        mode_r <= frame_r[4][2:0];
      end
    end
  end

  always_comb begin
    quot     = prod_r[PROD_W-1:ADC_W];
    part_sum = {1'b0, prod_r[ADC_W-1:0]} + {2'b0, quot};
    val_nxt  = (part_sum >= 11'(ADC_FULL)) ? quot + 1'b1 : quot;
    hund_nxt = '0;
    for (int h = 1; h <= 5; h++) begin
      if (val_r >= VAL_W'(h * 100)) begin
        hund_nxt = 3'(h);
      end
    end
    rem_nxt  = 7'(val_r - VAL_W'(hund_nxt) * VAL_W'(100));
    tens_nxt = '0;
    for (int t = 1; t < 10; t++) begin
      if (rem_r >= 7'(t * 10)) begin
        tens_nxt = 4'(t);
      end
    end
    ones_nxt = 4'(rem_r - 7'(tens_nxt) * 7'd10);
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    hund_r <= hund_nxt;
    rem_r  <= rem_nxt;
    tens_r <= tens_nxt;
    ones_r <= ones_nxt;
  end

  always_comb begin
    kind_nxt  = KIND_DATA;
    obyte_nxt = CHAR_C;
    oref_nxt  = 2'd0;
    unique case (cmd.sel)
      SEL_ECHO: begin
        kind_nxt  = KIND_ECHO;
        obyte_nxt = byte_r;
      end
      SEL_REF: begin
        kind_nxt  = KIND_REF;
        obyte_nxt = 8'd0;
        oref_nxt  = ref_r;
      end
      SEL_HUND:   obyte_nxt = CHAR_ZERO | {5'd0, hund_r};
      SEL_TENS:   obyte_nxt = CHAR_ZERO | {4'd0, tens_r};
      SEL_ONES:   obyte_nxt = CHAR_ZERO | {4'd0, ones_r};
      SEL_LETTER: obyte_nxt = CHAR_C;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind_nxt;
      obyte_r <= obyte_nxt;
      oref_r  <= oref_nxt;
      omode_r <= mode_r;
      olast_r <= cmd.last;
    end
  end

  assign stat.reply    = reply_r;
  assign stat.out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.out_byte   = obyte_r;
  assign out_ch.ref_number = oref_r;
  assign out_ch.mode       = omode_r;
  assign out_ch.last       = olast_r;

  `ACFP_ASSERT_IMP(a_load_free, clk, rst_n, cmd.load, stat.out_free, "load into busy output")
  `ACFP_ASSERT_NXT(a_load_valid, clk, rst_n, cmd.load, out_valid_r, "result not shown")
  `ACFP_ASSERT_NXT(a_mode_hold, clk, rst_n, !cmd.decode, $stable(mode_r), "mode moved")

endmodule

>>> hw/rtl/acfp_ctrl.sv
// Controller: sequences capture, decode and the result transactions of one byte.
module acfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  acfp_pkg::acfp_stat_t stat,
  output acfp_pkg::acfp_cmd_t  cmd
);
  import acfp_pkg::*;
`include "addressed_command_frame_parser_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ECHO,
    ST_REF,
    ST_HUND,
    ST_TENS,
    ST_ONES,
    ST_LETTER
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.decode  = 1'b0;
    cmd.load    = 1'b0;
    cmd.sel     = SEL_ECHO;
    cmd.last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.decode = 1'b1;
        state_nxt  = ST_ECHO;
      end
      ST_ECHO: begin
        if (stat.out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_ECHO;
          unique case (stat.reply)
            REPLY_REF: state_nxt = ST_REF;
            REPLY_CO:  state_nxt = ST_HUND;
            default: begin
              cmd.last  = 1'b1;
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_REF: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_REF;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_HUND: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_HUND;
          state_nxt = ST_TENS;
        end
      end
      ST_TENS: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_TENS;
          state_nxt = ST_ONES;
        end
      end
      ST_ONES: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_ONES;
          state_nxt = ST_LETTER;
        end
      end
      ST_LETTER: begin
        if (stat.out_free) begin
          cmd.load  = 1'b1;
          cmd.sel   = SEL_LETTER;
          cmd.last  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

  `ACFP_ASSERT_IMP(a_cap_ready, clk, rst_n, cmd.capture, in_ready, "capture while busy")
  `ACFP_ASSERT_NXT(a_cap_decode, clk, rst_n, cmd.capture, state_r == ST_DECODE, "no decode")
  `ACFP_ASSERT_NXT(a_last_idle, clk, rst_n, cmd.load && cmd.last, in_ready, "not idle")

endmodule

>>> hw/rtl/addressed_command_frame_parser.sv
// Top level of the addressed command frame parser.
// The echo is presented after the byte is captured, decoded and loaded into the output register.
// A new byte is taken only in idle, after the echo, the reference number with a reference request
// or three digits and a letter with a CO reply, as the controller emits one result per cycle
// into one output register while it is free; output stalls hold the controller in its state.
// Reset: synchronous, active low; clears frame buffer, fill index, mode and address.
module addressed_command_frame_parser #(
  parameter int BUF_DEPTH = acfp_pkg::ACFP_BUF_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  acfp_in_if.sink     in_ch,
  acfp_out_if.source  out_ch,
  acfp_cfg_if.sink    cfg_ch
);
  import acfp_pkg::*;

  acfp_cmd_t  cmd;
  acfp_stat_t stat;
  logic       in_ready;

  assign in_ch.ready = in_ready;

  acfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  acfp_dpath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .rx_byte   (in_ch.rx_byte),
    .adc_value (in_ch.adc_value),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_ch    (cfg_ch),
    .out_ch    (out_ch)
  );

endmodule
